// ----- rtl/format_string_tokenizer_macros.svh -----
// assertion macros shared by the tokenizer checker
// expects signals named clock and reset in the scope of use
`ifndef FORMAT_STRING_TOKENIZER_MACROS_SVH
`define FORMAT_STRING_TOKENIZER_MACROS_SVH

// same-cycle implication, disabled during reset
`define FST_ASSERT_IMPL(label, ant, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ant) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define FST_ASSERT_NEXT(label, ant, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ant) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/fst_pkg.sv -----
// types and constants of the format string tokenizer
// used by the top level and its checker; no dependencies
package fst_pkg;

   localparam logic [7:0] CH_OPEN  = 8'h7B;
   localparam logic [7:0] CH_CLOSE = 8'h7D;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_COLON = 8'h3A;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_OPEN  = 2'd1;
   localparam logic [1:0] ERR_CLOSE = 2'd2;

   typedef enum logic [2:0] {
      MODE_LITERAL    = 3'd0,
      MODE_OPEN_PEND  = 3'd1,
      MODE_CLOSE_PEND = 3'd2,
      MODE_NAME       = 3'd3,
      MODE_CONV       = 3'd4,
      MODE_SPEC       = 3'd5,
      MODE_ERROR      = 3'd6
   } mode_type;

   typedef enum logic [2:0] {
      KIND_LITERAL = 3'd0,
      KIND_NAME    = 3'd1,
      KIND_CONV    = 3'd2,
      KIND_SPEC    = 3'd3,
      KIND_CLOSED  = 3'd4,
      KIND_END     = 3'd5,
      KIND_ERROR   = 3'd6
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] out_char;
      logic [1:0] err_code;
      logic       trailing_chunk;
      logic       done_res;
   } result_type;

endpackage

// ----- rtl/format_string_tokenizer.sv -----
// format string tokenizer: one character per request, one result register
// results are registered: a result appears in the cycle after the request that causes it
// throughput: one request per cycle; ready drops only while a result is stalled
// reset: synchronous, returns to literal mode with no error and an empty result register
// depends on fst_pkg
module format_string_tokenizer
   import fst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_char
   input  logic [0:0]  req_tuser,   // [0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_char, [9:8] err_code, [10] trailing_chunk
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   output logic        rsp_tlast    // done_res
);

   mode_type   mode_ff, mode_in;
   logic       lit_pend_ff, lit_pend_in;
   logic       chunk_seen_ff, chunk_seen_in;
   logic [1:0] sticky_err_ff, sticky_err_in;
   logic       rsp_valid_ff;
   result_type rsp_ff;

   logic       accept;
   logic       res_valid;
   result_type res;
   logic [7:0] ch;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign ch         = req_tdata;

   always_comb begin
      mode_in       = mode_ff;
      lit_pend_in   = lit_pend_ff;
      chunk_seen_in = chunk_seen_ff;
      sticky_err_in = sticky_err_ff;
      res_valid     = 1'b0;
      res.kind           = KIND_LITERAL;
      res.out_char       = 8'd0;
      res.err_code       = ERR_NONE;
      res.trailing_chunk = 1'b0;
      res.done_res       = 1'b0;
      if (req_tuser[0]) begin
         // end of text: report and return to reset state
         res_valid     = 1'b1;
         res.done_res  = 1'b1;
         mode_in       = MODE_LITERAL;
         lit_pend_in   = 1'b0;
         chunk_seen_in = 1'b0;
         sticky_err_in = ERR_NONE;
         case (mode_ff)
            MODE_LITERAL: begin
               res.kind           = KIND_END;
               res.trailing_chunk = lit_pend_ff || !chunk_seen_ff;
            end
            MODE_CLOSE_PEND: begin
               res.kind     = KIND_ERROR;
               res.err_code = ERR_CLOSE;
            end
            MODE_ERROR: begin
               res.kind     = KIND_ERROR;
               res.err_code = sticky_err_ff;
            end
            default: begin
               res.kind     = KIND_ERROR;
               res.err_code = ERR_OPEN;
            end
         endcase
      end else begin
         case (mode_ff)
            MODE_LITERAL: begin
               if (ch == CH_OPEN) begin
                  mode_in = MODE_OPEN_PEND;
               end else if (ch == CH_CLOSE) begin
                  mode_in = MODE_CLOSE_PEND;
               end else begin
                  lit_pend_in  = 1'b1;
                  res_valid    = 1'b1;
                  res.out_char = ch;
               end
            end
            MODE_OPEN_PEND: begin
               if (ch == CH_OPEN) begin
                  mode_in      = MODE_LITERAL;
                  lit_pend_in  = 1'b1;
                  res_valid    = 1'b1;
                  res.out_char = ch;
               end else if (ch == CH_CLOSE) begin
                  mode_in       = MODE_LITERAL;
                  lit_pend_in   = 1'b0;
                  chunk_seen_in = 1'b1;
                  res_valid     = 1'b1;
                  res.kind      = KIND_CLOSED;
               end else if (ch == CH_BANG) begin
                  mode_in = MODE_CONV;
               end else if (ch == CH_COLON) begin
                  mode_in = MODE_SPEC;
               end else begin
                  mode_in      = MODE_NAME;
                  res_valid    = 1'b1;
                  res.kind     = KIND_NAME;
                  res.out_char = ch;
               end
            end
            MODE_CLOSE_PEND: begin
               res_valid = 1'b1;
               if (ch == CH_CLOSE) begin
                  mode_in      = MODE_LITERAL;
                  lit_pend_in  = 1'b1;
                  res.out_char = ch;
               end else begin
                  // lone close brace, the following character is dropped
                  mode_in       = MODE_ERROR;
                  sticky_err_in = ERR_CLOSE;
                  res.kind      = KIND_ERROR;
                  res.err_code  = ERR_CLOSE;
               end
            end
            MODE_NAME, MODE_CONV, MODE_SPEC: begin
               if (ch == CH_CLOSE) begin
                  mode_in       = MODE_LITERAL;
                  lit_pend_in   = 1'b0;
                  chunk_seen_in = 1'b1;
                  res_valid     = 1'b1;
                  res.kind      = KIND_CLOSED;
               end else if (ch == CH_BANG && mode_ff == MODE_NAME) begin
                  mode_in = MODE_CONV;
               end else if (ch == CH_COLON && mode_ff != MODE_SPEC) begin
                  mode_in = MODE_SPEC;
               end else begin
                  res_valid    = 1'b1;
                  res.out_char = ch;
                  if (mode_ff == MODE_NAME) begin
                     res.kind = KIND_NAME;
                  end else if (mode_ff == MODE_CONV) begin
                     res.kind = KIND_CONV;
                  end else begin
                     res.kind = KIND_SPEC;
                  end
               end
            end
            default: begin
               // error mode: drop the character
               mode_in = MODE_ERROR;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_LITERAL;
         lit_pend_ff   <= 1'b0;
         chunk_seen_ff <= 1'b0;
         sticky_err_ff <= ERR_NONE;
      end else if (accept) begin
         mode_ff       <= mode_in;
         lit_pend_ff   <= lit_pend_in;
         chunk_seen_ff <= chunk_seen_in;
         sticky_err_ff <= sticky_err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.done_res;
   assign rsp_tdata  = {5'd0, rsp_ff.trailing_chunk, rsp_ff.err_code, rsp_ff.out_char};

endmodule

// ----- rtl/fst_checker.sv -----
// port-level checks of the format string tokenizer, bound to the top level
// depends on fst_pkg and format_string_tokenizer_macros.svh
`include "format_string_tokenizer_macros.svh"

module fst_checker
   import fst_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // a stalled result keeps its contents
   `FST_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled result changed")

   // an end report always closes the string
   `FST_ASSERT_IMPL(a_end_last, rsp_tvalid && rsp_tuser == KIND_END, rsp_tlast, "end report without last")

   // error reports carry a code, other kinds none
   `FST_ASSERT_IMPL(a_err_code, rsp_tvalid, (rsp_tuser == KIND_ERROR) == (rsp_tdata[9:8] != ERR_NONE), "error code mismatch")

   // trailing chunk flag only on the end report, no character on control kinds
   `FST_ASSERT_IMPL(a_ctrl_clean, rsp_tvalid && (rsp_tuser == KIND_CLOSED || rsp_tuser == KIND_END || rsp_tuser == KIND_ERROR), rsp_tdata[7:0] == 8'd0 && (rsp_tdata[10] == 1'b0 || rsp_tuser == KIND_END), "control result carries data")

endmodule

bind format_string_tokenizer fst_checker u_fst_checker (.*);

// ----- tb/sv/tb_format_string_tokenizer.sv -----
`timescale 1ns / 1ps
// testbench for format_string_tokenizer: drives format strings as character requests
// and checks every token against an internal predictor; depends on fst_pkg and the rtl
module tb_format_string_tokenizer;
   import fst_pkg::*;

   localparam int ITEMS_TARGET = 450;
   localparam int CYCLE_LIMIT  = 200000;

   // expected token stream and the tokenizer state behind it
   class token_scoreboard;
      mode_type   mode;
      bit         literal_seen;
      bit         field_seen;
      logic [1:0] held_error;
      result_type expected_tokens[$];
      int         mismatches;

      function new();
         restart();
         mismatches = 0;
      endfunction

      function void restart();
         mode = MODE_LITERAL;
         literal_seen = 1'b0;
         field_seen = 1'b0;
         held_error = ERR_NONE;
      endfunction

      function int outstanding();
         return expected_tokens.size();
      endfunction

      function result_type char_token(kind_type k, logic [7:0] c);
         result_type t;
         t = '0;
         t.kind = k;
         t.out_char = c;
         return t;
      endfunction

      function result_type field_closed();
         result_type t;
         t = '0;
         t.kind = KIND_CLOSED;
         mode = MODE_LITERAL;
         literal_seen = 1'b0;
         field_seen = 1'b1;
         return t;
      endfunction

      function string show(result_type t);
         return $sformatf("kind %0d char %02h err %0d trail %0b last %0b",
                          t.kind, t.out_char, t.err_code, t.trailing_chunk, t.done_res);
      endfunction

      function void note_request(bit is_end, logic [7:0] ch);
         result_type r;
         bit emits;
         r = '0;
         emits = 1'b1;
         if (is_end) begin
            r.done_res = 1'b1;
            case (mode)
               MODE_LITERAL: begin
                  r.kind = KIND_END;
                  r.trailing_chunk = literal_seen || !field_seen;
               end
               MODE_CLOSE_PEND: begin
                  r.kind = KIND_ERROR;
                  r.err_code = ERR_CLOSE;
               end
               MODE_ERROR: begin
                  r.kind = KIND_ERROR;
                  r.err_code = held_error;
               end
               default: begin
                  r.kind = KIND_ERROR;
                  r.err_code = ERR_OPEN;
               end
            endcase
            restart();
         end else begin
            case (mode)
               MODE_LITERAL: begin
                  if (ch == CH_OPEN) begin
                     mode = MODE_OPEN_PEND;
                     emits = 1'b0;
                  end else if (ch == CH_CLOSE) begin
                     mode = MODE_CLOSE_PEND;
                     emits = 1'b0;
                  end else begin
                     literal_seen = 1'b1;
                     r = char_token(KIND_LITERAL, ch);
                  end
               end
               MODE_OPEN_PEND: begin
                  if (ch == CH_OPEN) begin
                     mode = MODE_LITERAL;
                     literal_seen = 1'b1;
                     r = char_token(KIND_LITERAL, ch);
                  end else if (ch == CH_CLOSE) begin
                     r = field_closed();
                  end else if (ch == CH_BANG) begin
                     mode = MODE_CONV;
                     emits = 1'b0;
                  end else if (ch == CH_COLON) begin
                     mode = MODE_SPEC;
                     emits = 1'b0;
                  end else begin
                     mode = MODE_NAME;
                     r = char_token(KIND_NAME, ch);
                  end
               end
               MODE_CLOSE_PEND: begin
                  if (ch == CH_CLOSE) begin
                     mode = MODE_LITERAL;
                     literal_seen = 1'b1;
                     r = char_token(KIND_LITERAL, ch);
                  end else begin
                     // lone close brace: the character after it is dropped
                     mode = MODE_ERROR;
                     held_error = ERR_CLOSE;
                     r.kind = KIND_ERROR;
                     r.err_code = ERR_CLOSE;
                  end
               end
               MODE_NAME: begin
                  if (ch == CH_CLOSE) r = field_closed();
                  else if (ch == CH_BANG) begin
                     mode = MODE_CONV;
                     emits = 1'b0;
                  end else if (ch == CH_COLON) begin
                     mode = MODE_SPEC;
                     emits = 1'b0;
                  end else r = char_token(KIND_NAME, ch);
               end
               MODE_CONV: begin
                  if (ch == CH_CLOSE) r = field_closed();
                  else if (ch == CH_COLON) begin
                     mode = MODE_SPEC;
                     emits = 1'b0;
                  end else r = char_token(KIND_CONV, ch);
               end
               MODE_SPEC: begin
                  if (ch == CH_CLOSE) r = field_closed();
                  else r = char_token(KIND_SPEC, ch);
               end
               default: begin
                  emits = 1'b0;
               end
            endcase
         end
         if (emits) expected_tokens.insert(expected_tokens.size(), r);
      endfunction

      function void note_mismatch(string msg);
         mismatches++;
         if (mismatches <= 10) $display("token mismatch at %0t: %s", $realtime, msg);
      endfunction

      function void check_token(result_type got);
         result_type want;
         if (expected_tokens.size() == 0) begin
            note_mismatch({"unexpected token ", show(got)});
            return;
         end
         want = expected_tokens.pop_front();
         if (got.kind !== want.kind || got.out_char !== want.out_char ||
             got.err_code !== want.err_code || got.trailing_chunk !== want.trailing_chunk ||
             got.done_res !== want.done_res)
            note_mismatch({"expected ", show(want), ", got ", show(got)});
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] text_char
   logic [0:0]  req_tuser = 1'b0;    // [0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // [7:0] out_char, [9:8] err_code, [10] trailing_chunk
   logic [2:0]  rsp_tuser;           // [2:0] kind
   logic        rsp_tlast;

   token_scoreboard tokens_sb = new();
   result_type      seen_token;
   bit              quiet = 1'b0;
   int              items_sent = 0;
   int              cycle_count = 0;
   bit              paused_mid = 1'b0;

   format_string_tokenizer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // token sink with random back-pressure
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         seen_token.kind = kind_type'(rsp_tuser);
         seen_token.out_char = rsp_tdata[7:0];
         seen_token.err_code = rsp_tdata[9:8];
         seen_token.trailing_chunk = rsp_tdata[10];
         seen_token.done_res = rsp_tlast;
         tokens_sb.check_token(seen_token);
      end
      rsp_tready <= quiet || ($urandom_range(99) >= 31);
   end

   task automatic send_item(input bit is_end, input logic [7:0] ch);
      if (!quiet && $urandom_range(99) < 31) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 31);
      end
      req_tvalid <= 1'b1;
      req_tuser <= is_end;
      req_tdata <= ch;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      tokens_sb.note_request(is_end, ch);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      foreach (s[i]) send_item(1'b0, s[i]);
   endtask

   task automatic drain_tokens();
      req_tvalid <= 1'b0;
      while (tokens_sb.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do c = 8'($urandom_range(255)); while (c == CH_OPEN || c == CH_CLOSE);
      return c;
   endfunction

   // text inside a field, with separators and open braces mixed in
   function automatic logic [7:0] part_char(int unsigned extra_pct);
      logic [7:0] c;
      if ($urandom_range(99) < extra_pct) begin
         case ($urandom_range(2))
            0: c = CH_OPEN;
            1: c = CH_BANG;
            default: c = CH_COLON;
         endcase
      end else c = plain_char();
      return c;
   endfunction

   function automatic logic [7:0] noise_char();
      logic [7:0] c;
      case ($urandom_range(5))
         0: c = CH_OPEN;
         1: c = CH_CLOSE;
         2: c = CH_BANG;
         3: c = CH_COLON;
         default: c = 8'($urandom_range(255));
      endcase
      return c;
   endfunction

   task automatic send_literal_run();
      int unsigned n;
      logic [7:0] b;
      n = $urandom_range(4);
      repeat (n) begin
         if ($urandom_range(5) == 0) begin
            b = $urandom_range(1) ? CH_OPEN : CH_CLOSE;
            send_item(1'b0, b);
            send_item(1'b0, b);
         end else send_item(1'b0, plain_char());
      end
   endtask

   task automatic send_field();
      int unsigned n;
      send_item(1'b0, CH_OPEN);
      n = $urandom_range(3);
      repeat (n) send_item(1'b0, part_char(5));
      if ($urandom_range(1)) begin
         send_item(1'b0, CH_BANG);
         n = $urandom_range(2);
         repeat (n) send_item(1'b0, part_char(20));
      end
      if ($urandom_range(1)) begin
         send_item(1'b0, CH_COLON);
         n = $urandom_range(3);
         repeat (n) send_item(1'b0, part_char(30));
      end
      send_item(1'b0, CH_CLOSE);
   endtask

   task automatic send_random_string();
      int unsigned shape;
      int unsigned n;
      shape = $urandom_range(99);
      if (shape < 85) begin
         n = $urandom_range(1, 4);
         repeat (n) begin
            if ($urandom_range(1)) send_literal_run();
            else send_field();
         end
         // broken tail: unterminated field or lone close brace
         if (shape >= 70) begin
            if ($urandom_range(1)) begin
               send_item(1'b0, CH_OPEN);
               repeat ($urandom_range(2)) send_item(1'b0, plain_char());
            end else begin
               send_item(1'b0, CH_CLOSE);
               repeat ($urandom_range(1, 3)) send_item(1'b0, 8'($urandom_range(255)));
            end
         end
      end else begin
         n = $urandom_range(1, 12);
         repeat (n) send_item(1'b0, noise_char());
      end
      send_item(1'b1, 8'($urandom_range(255)));
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'hFF);
      send_text("{{}}");
      send_text("{x!r!:s:!}");
      send_item(1'b1, 8'hFF);
      send_text("{}z");
      send_item(1'b1, 8'h00);
      send_text("}qw");
      send_item(1'b1, 8'h00);
      send_text("{");
      send_item(1'b1, 8'h00);
      send_text("}");
      send_item(1'b1, 8'h00);
      send_text("{:{");
      send_item(1'b1, 8'h00);
      send_item(1'b1, 8'h00);
      drain_tokens();

      while (items_sent < ITEMS_TARGET) begin
         quiet = (items_sent >= 180 && items_sent < 280);
         if (!paused_mid && items_sent >= 320) begin
            drain_tokens();
            paused_mid = 1'b1;
         end
         send_random_string();
      end
      quiet = 1'b0;

      drain_tokens();
      if (tokens_sb.mismatches == 0 && tokens_sb.outstanding() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
